[rtl/fdp_pkg.sv]
// shared constants, types and helper functions of the fat directory entry parser
package fdp_pkg;

  localparam int MAX_LONG_ENTRIES = 20;
  localparam int CHARS_PER_ENTRY  = 13;
  localparam int ROW_W            = 8 * CHARS_PER_ENTRY;
  localparam int ROW_AW           = $clog2(MAX_LONG_ENTRIES);
  localparam int ENTRY_W          = 256;

  localparam logic [7:0] DELETED_MARK      = 8'hE5;
  localparam logic [7:0] LFN_LAST_FLAG     = 8'h40;
  localparam logic [7:0] ATTR_LONG_NAME    = 8'h0F;
  localparam logic [7:0] CHAR_SPACE        = 8'h20;
  localparam logic [7:0] CHAR_DOT          = 8'h2E;
  localparam logic [7:0] CHAR_UPPER_A      = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z      = 8'h5A;
  localparam logic [7:0] CASE_OFFSET       = 8'h20;
  localparam int         ATTR_DIR_BIT      = 4;
  localparam int         LOW_NAME_BIT      = 3;
  localparam int         LOW_EXT_BIT       = 4;

  localparam logic [7:0] LFN_OFFSETS [CHARS_PER_ENTRY] =
    '{8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd14, 8'd16, 8'd18, 8'd20, 8'd22, 8'd24, 8'd28, 8'd30};

  // short name walk positions: name bytes, dot slot, extension bytes, done
  localparam logic [3:0] POS_DOT  = 4'd8;
  localparam logic [3:0] POS_DONE = 4'd12;
  localparam logic [3:0] CSUM_LAST = 4'd10;
  localparam logic [3:0] COL_LAST  = 4'(CHARS_PER_ENTRY - 1);
  localparam logic [3:0] CHUNK_FULL = 4'd8;

  typedef enum logic [1:0] {
    KIND_CHUNK  = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_END    = 2'd2
  } fdp_kind_t;

  typedef enum logic [1:0] {
    DEC_NONE,
    DEC_END,
    DEC_LONG,
    DEC_SHORT
  } fdp_dec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CSUM,
    ST_LREAD,
    ST_LCHAR,
    ST_SHORT,
    ST_FLUSH,
    ST_REC,
    ST_END
  } fdp_state_t;

  typedef struct packed {
    logic in_rdy;
    logic decode;
    logic csum_step;
    logic lread;
    logic lchar_step;
    logic lrow_next;
    logic short_step;
    logic push_chunk;
    logic push_rec;
    logic push_end;
  } fdp_cmd_t;

  typedef struct packed {
    logic     in_valid;
    fdp_dec_t dec;
    logic     csum_last;
    logic     csum_match;
    logic     char_zero;
    logic     col_last;
    logic     row_zero;
    logic     short_done;
    logic     acc_full;
    logic     acc_empty;
    logic     any_char;
    logic     out_free;
  } fdp_sts_t;

  function automatic logic [7:0] entry_byte(input logic [ENTRY_W-1:0] e, input logic [4:0] idx);
    return e[idx*8 +: 8];
  endfunction

  function automatic logic [ROW_W-1:0] lfn_row(input logic [ENTRY_W-1:0] e);
    logic [ROW_W-1:0] row;
    row = '0;
    for (int j = 0; j < CHARS_PER_ENTRY; j++) begin
      row[j*8 +: 8] = e[LFN_OFFSETS[j]*8 +: 8];
    end
    return row;
  endfunction

  function automatic logic [7:0] lower_if(input logic [7:0] c, input logic on);
    if (on && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage

[rtl/fdp_if.sv]
// entry and result channel interfaces
interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] bytes_0_to_7;
  logic [63:0] bytes_8_to_15;
  logic [63:0] bytes_16_to_23;
  logic [63:0] bytes_24_to_31;
  logic        new_directory;
  modport source(output valid, bytes_0_to_7, bytes_8_to_15, bytes_16_to_23,
                 bytes_24_to_31, new_directory, input ready);
  modport sink(input valid, bytes_0_to_7, bytes_8_to_15, bytes_16_to_23,
               bytes_24_to_31, new_directory, output ready);
endinterface

interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] name_chunk;
  logic [3:0]  chunk_bytes;
  logic        is_folder;
  logic        read_only;
  logic        hidden;
  logic [31:0] first_cluster;
  logic [31:0] file_size;
  logic        last;
  modport source(output valid, kind, name_chunk, chunk_bytes, is_folder, read_only, hidden,
                 first_cluster, file_size, last, input ready);
  modport sink(input valid, kind, name_chunk, chunk_bytes, is_folder, read_only, hidden,
               first_cluster, file_size, last, output ready);
endinterface

[rtl/fdp_ctrl.sv]
// sequencer of the directory entry parser
module fdp_ctrl import fdp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fdp_sts_t sts,
  output fdp_cmd_t cmd
);

  fdp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.dec)
          DEC_NONE:  state_nxt = ST_IDLE;
          DEC_END:   state_nxt = ST_END;
          DEC_LONG:  state_nxt = ST_CSUM;
          DEC_SHORT: state_nxt = ST_SHORT;
          default:   state_nxt = ST_IDLE;
        endcase
      end
      ST_CSUM: begin
        if (sts.csum_last) state_nxt = sts.csum_match ? ST_LREAD : ST_SHORT;
      end
      ST_LREAD: state_nxt = ST_LCHAR;
      ST_LCHAR: begin
        if (!sts.acc_full) begin
          if (sts.char_zero) begin
            state_nxt = sts.any_char ? ST_FLUSH : ST_SHORT;
          end else if (sts.col_last) begin
            state_nxt = sts.row_zero ? ST_FLUSH : ST_LREAD;
          end
        end
      end
      ST_SHORT: begin
        if (!sts.acc_full && sts.short_done) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sts.acc_empty || sts.out_free) state_nxt = ST_REC;
      end
      ST_REC: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_END: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.in_rdy = 1'b1;
      ST_DECODE: cmd.decode = 1'b1;
      ST_CSUM:   cmd.csum_step = 1'b1;
      ST_LREAD:  cmd.lread = 1'b1;
      ST_LCHAR: begin
        if (sts.acc_full) begin
          cmd.push_chunk = sts.out_free;
        end else if (!sts.char_zero) begin
          cmd.lchar_step = 1'b1;
          cmd.lrow_next  = sts.col_last && !sts.row_zero;
        end
      end
      ST_SHORT: begin
        if (sts.acc_full) begin
          cmd.push_chunk = sts.out_free;
        end else if (!sts.short_done) begin
          cmd.short_step = 1'b1;
        end
      end
      ST_FLUSH: cmd.push_chunk = !sts.acc_empty && sts.out_free;
      ST_REC:   cmd.push_rec = sts.out_free;
      ST_END:   cmd.push_end = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/fdp_dp.sv]
// datapath: entry register, run state, long name store, name assembly, result register
module fdp_dp import fdp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  fdp_in_if.sink   in_ch,
  fdp_out_if.source out_ch,
  input  fdp_cmd_t cmd,
  output fdp_sts_t sts
);

  logic [ENTRY_W-1:0] e_r;
  logic               nd_r;
  logic [7:0]         rem_r, rem_nxt;
  logic [7:0]         tot_r, tot_nxt;
  logic [7:0]         csave_r, csave_nxt;
  logic               have_r, have_nxt;
  logic               ended_r, ended_nxt;

  logic [ROW_W-1:0]   mem [MAX_LONG_ENTRIES];
  logic [ROW_W-1:0]   mem_q_r;
  logic               wr_en;
  logic [7:0]         wr_idx;
  fdp_dec_t           dec;

  logic [7:0]         csum_r, csum_step_val;
  logic [3:0]         ci_r;
  logic [ROW_AW-1:0]  k_r;
  logic [3:0]         j_r;
  logic [3:0]         p_r, p_nxt;
  logic [63:0]        acc_r;
  logic [3:0]         cnt_r;
  logic               any_r;

  logic [7:0]         e0, e11, e12, lchar, sh_char, sh_byte;
  logic               sh_valid, is_lfn, out_free;
  logic [7:0]         count;

  logic        out_valid_r;
  fdp_kind_t   kind_r;
  logic [63:0] chunk_r;
  logic [3:0]  bytes_r;
  logic        folder_r, ro_r, hidden_r, last_r;
  logic [31:0] cluster_r, size_r;

  assign e0    = entry_byte(e_r, 5'd0);
  assign e11   = entry_byte(e_r, 5'd11);
  assign e12   = entry_byte(e_r, 5'd12);
  assign is_lfn = e11 == ATTR_LONG_NAME && e_r[223:208] == 16'd0;
  assign count = e0 & ~LFN_LAST_FLAG;

  // entry decode against the run state, with new_directory applied first
  always_comb begin
    rem_nxt   = nd_r ? 8'd0 : rem_r;
    tot_nxt   = nd_r ? 8'd0 : tot_r;
    have_nxt  = have_r & ~nd_r;
    ended_nxt = ended_r & ~nd_r;
    csave_nxt = csave_r;
    wr_en     = 1'b0;
    wr_idx    = 8'd0;
    dec       = DEC_NONE;
    if (ended_nxt) begin
      dec = DEC_NONE;
    end else if (rem_nxt != 8'd0) begin
      wr_idx  = tot_nxt - rem_nxt;
      wr_en   = wr_idx < 8'(MAX_LONG_ENTRIES);
      if (rem_nxt == 8'd1) have_nxt = 1'b1;
      rem_nxt = rem_nxt - 8'd1;
    end else if (have_nxt) begin
      have_nxt = 1'b0;
      if (e0 == 8'd0) begin
        ended_nxt = 1'b1;
        dec       = DEC_END;
      end else begin
        dec = (tot_nxt <= 8'(MAX_LONG_ENTRIES)) ? DEC_LONG : DEC_SHORT;
      end
    end else if (e0 == 8'd0) begin
      ended_nxt = 1'b1;
      dec       = DEC_END;
    end else if (e0 == DELETED_MARK) begin
      dec = DEC_NONE;
    end else if (is_lfn && count != 8'd0) begin
      tot_nxt   = count;
      csave_nxt = entry_byte(e_r, 5'd13);
      wr_en     = 1'b1;
      wr_idx    = 8'd0;
      rem_nxt   = count - 8'd1;
      have_nxt  = count == 8'd1;
    end else begin
      dec = DEC_SHORT;
    end
  end

  assign csum_step_val = {csum_r[0], csum_r[7:1]} + entry_byte(e_r, {1'b0, ci_r});
  assign lchar = mem_q_r[j_r*8 +: 8];

  // 8.3 name walk: name bytes, optional dot, extension bytes
  always_comb begin
    sh_valid = 1'b0;
    sh_char  = CHAR_DOT;
    sh_byte  = 8'd0;
    p_nxt    = p_r;
    if (p_r < POS_DOT) begin
      sh_byte = entry_byte(e_r, {1'b0, p_r});
      if (sh_byte == CHAR_SPACE) begin
        p_nxt = POS_DOT;
      end else begin
        sh_valid = 1'b1;
        sh_char  = lower_if(sh_byte, e12[LOW_NAME_BIT]);
        p_nxt    = p_r + 4'd1;
      end
    end else if (p_r == POS_DOT) begin
      sh_valid = !e11[ATTR_DIR_BIT] && entry_byte(e_r, 5'd8) != CHAR_SPACE;
      p_nxt    = p_r + 4'd1;
    end else if (p_r < POS_DONE) begin
      sh_byte = entry_byte(e_r, {1'b0, p_r - 4'd1});
      if (sh_byte == CHAR_SPACE) begin
        p_nxt = POS_DONE;
      end else begin
        sh_valid = 1'b1;
        sh_char  = lower_if(sh_byte, e12[LOW_EXT_BIT]);
        p_nxt    = p_r + 4'd1;
      end
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_rdy) begin
      e_r  <= {in_ch.bytes_24_to_31, in_ch.bytes_16_to_23, in_ch.bytes_8_to_15,
               in_ch.bytes_0_to_7};
      nd_r <= in_ch.new_directory;
    end
    if (cmd.decode && wr_en) mem[wr_idx[ROW_AW-1:0]] <= lfn_row(e_r);
    if (cmd.lread) mem_q_r <= mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      tot_r   <= '0;
      csave_r <= '0;
      have_r  <= 1'b0;
      ended_r <= 1'b0;
    end else if (cmd.decode) begin
      rem_r   <= rem_nxt;
      tot_r   <= tot_nxt;
      csave_r <= csave_nxt;
      have_r  <= have_nxt;
      ended_r <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      any_r <= 1'b0;
      acc_r <= '0;
    end else if (cmd.decode || cmd.push_chunk) begin
      cnt_r <= '0;
      acc_r <= '0;
      if (cmd.decode) any_r <= 1'b0;
    end else if (cmd.lchar_step || (cmd.short_step && sh_valid)) begin
      acc_r[cnt_r[2:0]*8 +: 8] <= cmd.lchar_step ? lchar : sh_char;
      cnt_r <= cnt_r + 4'd1;
      any_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      csum_r <= '0;
      ci_r   <= '0;
      p_r    <= '0;
      j_r    <= '0;
      k_r    <= ROW_AW'(tot_r - 8'd1);
    end else begin
      if (cmd.csum_step) begin
        csum_r <= csum_step_val;
        ci_r   <= ci_r + 4'd1;
      end
      if (cmd.short_step) p_r <= p_nxt;
      if (cmd.lread) j_r <= '0;
      else if (cmd.lchar_step) j_r <= j_r + 4'd1;
      if (cmd.lrow_next) k_r <= k_r - ROW_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_chunk || cmd.push_rec || cmd.push_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_chunk || cmd.push_rec || cmd.push_end) begin
      kind_r    <= cmd.push_chunk ? KIND_CHUNK : (cmd.push_rec ? KIND_RECORD : KIND_END);
      chunk_r   <= cmd.push_chunk ? acc_r : 64'd0;
      bytes_r   <= cmd.push_chunk ? cnt_r : 4'd0;
      folder_r  <= cmd.push_rec & e11[ATTR_DIR_BIT];
      ro_r      <= cmd.push_rec & e11[0];
      hidden_r  <= cmd.push_rec & e11[1];
      cluster_r <= cmd.push_rec ? {e_r[175:160], e_r[223:208]} : 32'd0;
      size_r    <= cmd.push_rec ? e_r[255:224] : 32'd0;
      last_r    <= !cmd.push_chunk;
    end
  end

  assign in_ch.ready          = cmd.in_rdy;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.name_chunk    = chunk_r;
  assign out_ch.chunk_bytes   = bytes_r;
  assign out_ch.is_folder     = folder_r;
  assign out_ch.read_only     = ro_r;
  assign out_ch.hidden        = hidden_r;
  assign out_ch.first_cluster = cluster_r;
  assign out_ch.file_size     = size_r;
  assign out_ch.last          = last_r;

  assign sts.in_valid   = in_ch.valid;
  assign sts.dec        = dec;
  assign sts.csum_last  = ci_r == CSUM_LAST;
  assign sts.csum_match = csum_step_val == csave_r;
  assign sts.char_zero  = lchar == 8'd0;
  assign sts.col_last   = j_r == COL_LAST;
  assign sts.row_zero   = k_r == '0;
  assign sts.short_done = p_r == POS_DONE;
  assign sts.acc_full   = cnt_r == CHUNK_FULL;
  assign sts.acc_empty  = cnt_r == 4'd0;
  assign sts.any_char   = any_r;
  assign sts.out_free   = out_free;

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_chunk || cmd.push_rec || cmd.push_end) |-> out_free)
    else $error("result pushed into a full output register");
  a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push_chunk, cmd.push_rec, cmd.push_end}))
    else $error("more than one result pushed in a cycle");
  a_acc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CHUNK_FULL)
    else $error("chunk byte count overflow");
  a_end_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_end |-> ended_r)
    else $error("end marker without ended directory");

endmodule

[rtl/fat_directory_entry_parser.sv]
// top level of the fat directory entry parser
// in_ch takes one 32-byte directory entry per word (valid/ready), with
// new_directory to restart run and end state before the entry.
// out_ch gives name chunk words, then one record word with last set, or a
// single end marker word; deleted, long-name and post-end entries give none.
// An entry is decoded in the cycle after it is taken. A short entry then goes
// through the 8.3 walk (at most 12 steps), one push per chunk, a flush and
// a record push. A long name adds the checksum over the 11 short name bytes
// and, if it matches, one store read per 13-character row and one step per
// character, for names of up to 260 characters. One entry is in flight at a
// time: in_ch is ready only while the sequencer is idle.
// The output register holds a word until taken; while out_ch is stalled the
// name walk pauses once a chunk is full, and every push waits for it.
// Synchronous reset clears the run state, the ended flag and the output
// valid; the long name store needs no clearing since rows are read only
// after the current run has written them.
module fat_directory_entry_parser import fdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fdp_in_if.sink    in_ch,
  fdp_out_if.source out_ch
);

  fdp_cmd_t cmd;
  fdp_sts_t sts;

  fdp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  fdp_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
